// File: hw/rtl/gete_pkg.sv
// gete_pkg: widths, constants and shared types of the gaussian/exponential-tail evaluator
// no dependencies; used by every module of the block

package gete_pkg;

  // fixed point format of sample, registers and density
  localparam int FRAC_BITS = 16;

  localparam int IN_W      = 32;
  localparam int OUT_W     = 32;
  localparam int WIDTH_W   = 31;
  localparam int CFG_IDX_W = 2;

  // (|a - b| << FRAC_BITS) / width
  localparam int DIFF_W = IN_W + 1;
  localparam int DIV_W  = DIFF_W + FRAC_BITS;
  localparam int REM_W  = WIDTH_W;

  // exponent product: clamps once the product reaches 64.0 << (FRAC_BITS + 1)
  localparam int MUL_W    = 2 * FRAC_BITS + 7;
  localparam int MUL_LO_W = FRAC_BITS + 4;
  localparam int MUL_HI_W = MUL_W - MUL_LO_W;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int T_W      = FRAC_BITS + 7;
  localparam logic [T_W-1:0] T_LIM = T_W'(1) << (FRAC_BITS + 6);

  // exp(t) = 2^k * exp(f * ln2)
  localparam int Q30     = 30;
  localparam int LOG2E_W = 31;
  localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [Q30-1:0]     LN2_Q30   = 30'd744261118;
  localparam int UM_W = T_W + LOG2E_W - FRAC_BITS;
  localparam int UB_W = UM_W + 1;
  localparam int E_W  = UB_W - Q30;
  localparam logic [UB_W-1:0] BIAS_Q30 = UB_W'(128) << Q30;
  localparam int ACC_W = 32;
  localparam logic [ACC_W-1:0] ONE_Q30 = ACC_W'(1) << Q30;
  localparam int HORNER_TERMS = 10;
  localparam int RECIP_W = 33;
  // floor(2^32 / n) for the series divisors
  localparam logic [RECIP_W-1:0] RECIP [1:HORNER_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824, 33'd858993459,
    33'd715827882,  33'd613566756,  33'd536870912,  33'd477218588,  33'd429496729
  };

  // final scaling: shift = e - 128 + FRAC_BITS - 30
  localparam int S_W        = E_W + 1;
  localparam int SH_BIAS    = 128 + Q30 - FRAC_BITS;
  localparam int MAX_UP     = 2;
  localparam int ZERO_SHIFT = 40;
  localparam int RND_W      = ZERO_SHIFT;

  typedef struct packed {
    logic tail;
    logic neg_a;
    logic neg_b;
  } gete_tag_t;

endpackage

// File: hw/rtl/gete_div.sv
// gete_div: two-lane pipelined restoring divider, one quotient bit per stage
// depends on gete_pkg

module gete_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  gete_pkg::gete_tag_t          in_tag,
  input  logic [gete_pkg::DIV_W-1:0]   in_num_a,
  input  logic [gete_pkg::DIV_W-1:0]   in_num_b,
  input  logic [gete_pkg::REM_W-1:0]   divisor,
  output logic                         out_valid,
  output gete_pkg::gete_tag_t          out_tag,
  output logic [gete_pkg::DIV_W-1:0]   out_quo_a,
  output logic [gete_pkg::DIV_W-1:0]   out_quo_b
);
  import gete_pkg::*;

  // dividend bits shift out at the top, quotient bits shift in at the bottom
  function automatic logic [REM_W+DIV_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [DIV_W-1:0] dq,
                                                      input logic [REM_W-1:0] dvs);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    trial = {rem, dq[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {diff[REM_W-1:0], dq[DIV_W-2:0], 1'b1};
    end
    return {trial[REM_W-1:0], dq[DIV_W-2:0], 1'b0};
  endfunction

  logic             vld_r   [DIV_W];
  gete_tag_t        tag_r   [DIV_W];
  logic [REM_W-1:0] rem_a_r [DIV_W];
  logic [REM_W-1:0] rem_b_r [DIV_W];
  logic [DIV_W-1:0] dq_a_r  [DIV_W];
  logic [DIV_W-1:0] dq_b_r  [DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_st
    logic                   vld_in;
    gete_tag_t              tag_in;
    logic [REM_W-1:0]       ra_in;
    logic [REM_W-1:0]       rb_in;
    logic [DIV_W-1:0]       qa_in;
    logic [DIV_W-1:0]       qb_in;
    logic [REM_W+DIV_W-1:0] step_a_nxt;
    logic [REM_W+DIV_W-1:0] step_b_nxt;

    if (i == 0) begin : g_first
      assign vld_in = in_valid;
      assign tag_in = in_tag;
      assign ra_in  = '0;
      assign rb_in  = '0;
      assign qa_in  = in_num_a;
      assign qb_in  = in_num_b;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign tag_in = tag_r[i-1];
      assign ra_in  = rem_a_r[i-1];
      assign rb_in  = rem_b_r[i-1];
      assign qa_in  = dq_a_r[i-1];
      assign qb_in  = dq_b_r[i-1];
    end

    assign step_a_nxt = div_step(ra_in, qa_in, divisor);
    assign step_b_nxt = div_step(rb_in, qb_in, divisor);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[i]               <= tag_in;
        {rem_a_r[i], dq_a_r[i]} <= step_a_nxt;
        {rem_b_r[i], dq_b_r[i]} <= step_b_nxt;
      end
    end
  end

  assign out_valid = vld_r[DIV_W-1];
  assign out_tag   = tag_r[DIV_W-1];
  assign out_quo_a = dq_a_r[DIV_W-1];
  assign out_quo_b = dq_b_r[DIV_W-1];

endmodule

// File: hw/rtl/gete_expo.sv
// gete_expo: forms the exponent magnitude from the two ratios, clamped at 64.0
// depends on gete_pkg; three register stages (select, partial products, sum)

module gete_expo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  gete_pkg::gete_tag_t         in_tag,
  input  logic [gete_pkg::DIV_W-1:0]  in_quo_a,
  input  logic [gete_pkg::DIV_W-1:0]  in_quo_b,
  output logic                        out_valid,
  output logic [gete_pkg::T_W-1:0]    out_t_mag,
  output logic                        out_t_pos,
  output logic                        out_tail
);
  import gete_pkg::*;

  // stage 1: signed ratios, q = r1 + 2d, operand select
  logic signed [DIV_W:0]   d_s;
  logic signed [DIV_W:0]   r1_s;
  logic signed [DIV_W+2:0] q_s;
  logic [DIV_W+2:0]        q_abs;
  logic [DIV_W-1:0]        a_w;
  logic [DIV_W+1:0]        b_w;
  logic                    r1_neg;
  logic                    q_neg;

  logic                    v1_r;
  logic [MUL_W-1:0]        a_r;
  logic [MUL_W-1:0]        b_r;
  logic                    big1_r;
  logic                    tpos1_r;
  logic                    tail1_r;

  always_comb begin
    d_s    = in_tag.neg_a ? -$signed({1'b0, in_quo_a}) : $signed({1'b0, in_quo_a});
    r1_s   = in_tag.neg_b ? -$signed({1'b0, in_quo_b}) : $signed({1'b0, in_quo_b});
    q_s    = (DIV_W+3)'(r1_s) + ((DIV_W+3)'(d_s) <<< 1);
    r1_neg = r1_s < 0;
    q_neg  = q_s[DIV_W+2];
    q_abs  = q_neg ? (DIV_W+3)'(-q_s) : (DIV_W+3)'(q_s);
    a_w    = in_tag.tail ? in_quo_b : in_quo_a;
    b_w    = in_tag.tail ? q_abs[DIV_W+1:0] : {2'b00, in_quo_a};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_w[MUL_W-1:0];
      b_r     <= b_w[MUL_W-1:0];
      // an operand beyond the clamp point with a nonzero partner saturates
      big1_r  <= ((|a_w[DIV_W-1:MUL_W]) || (|b_w[DIV_W+1:MUL_W])) && (|a_w) && (|b_w);
      tpos1_r <= in_tag.tail && (r1_neg != q_neg);
      tail1_r <= in_tag.tail;
    end
  end

  // stage 2: four partial products
  logic                           v2_r;
  logic [2*MUL_LO_W-1:0]          ll_r;
  logic [MUL_LO_W+MUL_HI_W-1:0]   lh_r;
  logic [MUL_LO_W+MUL_HI_W-1:0]   hl_r;
  logic [2*MUL_HI_W-1:0]          hh_r;
  logic                           big2_r;
  logic                           tpos2_r;
  logic                           tail2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= (2*MUL_LO_W)'(a_r[MUL_LO_W-1:0]) * (2*MUL_LO_W)'(b_r[MUL_LO_W-1:0]);
      lh_r    <= (MUL_LO_W+MUL_HI_W)'(a_r[MUL_LO_W-1:0])
               * (MUL_LO_W+MUL_HI_W)'(b_r[MUL_W-1:MUL_LO_W]);
      hl_r    <= (MUL_LO_W+MUL_HI_W)'(a_r[MUL_W-1:MUL_LO_W])
               * (MUL_LO_W+MUL_HI_W)'(b_r[MUL_LO_W-1:0]);
      hh_r    <= (2*MUL_HI_W)'(a_r[MUL_W-1:MUL_LO_W]) * (2*MUL_HI_W)'(b_r[MUL_W-1:MUL_LO_W]);
      big2_r  <= big1_r;
      tpos2_r <= tpos1_r;
      tail2_r <= tail1_r;
    end
  end

  // stage 3: sum, shift by FRAC_BITS+1, clamp
  logic [PROD_W-1:0] p_w;
  logic [T_W-1:0]    t_w;
  logic              v3_r;
  logic [T_W-1:0]    t3_r;
  logic              tpos3_r;
  logic              tail3_r;

  always_comb begin
    p_w = PROD_W'(ll_r)
        + (PROD_W'(lh_r) << MUL_LO_W)
        + (PROD_W'(hl_r) << MUL_LO_W)
        + (PROD_W'(hh_r) << (2*MUL_LO_W));
    if (big2_r || (|p_w[PROD_W-1:MUL_W])) begin
      t_w = T_LIM;
    end else begin
      t_w = T_W'(p_w[MUL_W-1:FRAC_BITS+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r    <= t_w;
      tpos3_r <= tpos2_r;
      tail3_r <= tail2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_t_mag = t3_r;
  assign out_t_pos = tpos3_r;
  assign out_tail  = tail3_r;

endmodule

// File: hw/rtl/gete_fexp.sv
// gete_fexp: fixed point exp of the exponent, series by pipelined horner steps
// depends on gete_pkg; holds the result register of the block

module gete_fexp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gete_pkg::T_W-1:0]    in_t_mag,
  input  logic                        in_t_pos,
  input  logic                        in_tail,
  output logic                        out_valid,
  output logic [gete_pkg::OUT_W-1:0]  out_density,
  output logic                        out_saturated,
  output logic                        out_tail
);
  import gete_pkg::*;

  typedef struct packed {
    logic [E_W-1:0] e;
    logic [Q30-1:0] v;
    logic           tail;
  } side_t;

  // u = |t| * log2(e)
  logic [T_W+LOG2E_W-1:0] um_prod;
  logic                   v1_r;
  logic [UM_W-1:0]        um_r;
  logic                   tpos1_r;
  logic                   tail1_r;

  assign um_prod = (T_W+LOG2E_W)'(in_t_mag) * (T_W+LOG2E_W)'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      um_r    <= um_prod[T_W+LOG2E_W-1:FRAC_BITS];
      tpos1_r <= in_t_pos;
      tail1_r <= in_tail;
    end
  end

  // biased split into integer e and fraction f
  logic [UB_W-1:0] ub_w;
  logic            v2_r;
  logic [E_W-1:0]  e2_r;
  logic [Q30-1:0]  f2_r;
  logic            tail2_r;

  assign ub_w = tpos1_r ? BIAS_Q30 + UB_W'(um_r) : BIAS_Q30 - UB_W'(um_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_r    <= ub_w[UB_W-1:Q30];
      f2_r    <= ub_w[Q30-1:0];
      tail2_r <= tail1_r;
    end
  end

  // v = f * ln2
  logic [2*Q30-1:0] v_prod;
  logic             v3_r;
  side_t            side3_r;

  assign v_prod = (2*Q30)'(f2_r) * (2*Q30)'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= '{e: e2_r, v: v_prod[2*Q30-1:Q30], tail: tail2_r};
    end
  end

  // horner: acc = 1 + ((acc * v) >> 30) / n, n from 10 down to 1, three stages each
  logic             hv1_r  [HORNER_TERMS];
  logic [ACC_W-1:0] hy1_r  [HORNER_TERMS];
  side_t            hs1_r  [HORNER_TERMS];
  logic             hv2_r  [HORNER_TERMS];
  logic [ACC_W-1:0] hy2_r  [HORNER_TERMS];
  logic [ACC_W-1:0] hq2_r  [HORNER_TERMS];
  side_t            hs2_r  [HORNER_TERMS];
  logic             hv3_r  [HORNER_TERMS];
  logic [ACC_W-1:0] hacc_r [HORNER_TERMS];
  side_t            hs3_r  [HORNER_TERMS];

  for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_term
    localparam int N = HORNER_TERMS - j;

    logic                     vld_in;
    logic [ACC_W-1:0]         acc_in;
    side_t                    side_in;
    logic [ACC_W+Q30-1:0]     ym;
    logic [ACC_W+RECIP_W-1:0] qm;
    logic [ACC_W+3:0]         qn;
    logic [ACC_W-1:0]         rem_w;
    logic [ACC_W-1:0]         q_w;

    if (j == 0) begin : g_first
      assign vld_in  = v3_r;
      assign acc_in  = ONE_Q30;
      assign side_in = side3_r;
    end else begin : g_next
      assign vld_in  = hv3_r[j-1];
      assign acc_in  = hacc_r[j-1];
      assign side_in = hs3_r[j-1];
    end

    assign ym    = (ACC_W+Q30)'(acc_in) * (ACC_W+Q30)'(side_in.v);
    // reciprocal multiply, then one correction step
    assign qm    = (ACC_W+RECIP_W)'(hy1_r[j]) * (ACC_W+RECIP_W)'(RECIP[N]);
    assign qn    = (ACC_W+4)'(hq2_r[j]) * (ACC_W+4)'(N);
    assign rem_w = hy2_r[j] - qn[ACC_W-1:0];
    assign q_w   = (rem_w >= ACC_W'(N)) ? hq2_r[j] + ACC_W'(1) : hq2_r[j];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv1_r[j] <= 1'b0;
        hv2_r[j] <= 1'b0;
        hv3_r[j] <= 1'b0;
      end else if (en) begin
        hv1_r[j] <= vld_in;
        hv2_r[j] <= hv1_r[j];
        hv3_r[j] <= hv2_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hy1_r[j]  <= ym[ACC_W+Q30-1:Q30];
        hs1_r[j]  <= side_in;
        hy2_r[j]  <= hy1_r[j];
        hq2_r[j]  <= qm[ACC_W+RECIP_W-2:RECIP_W-1];
        hs2_r[j]  <= hs1_r[j];
        hacc_r[j] <= ONE_Q30 + q_w;
        hs3_r[j]  <= hs2_r[j];
      end
    end
  end

  // scale by 2^(e - SH_BIAS): left shift exact or saturated, right shift rounded half up or zero
  logic [ACC_W-1:0]  acc_f;
  side_t             side_f;
  logic signed [S_W-1:0] sh_s;
  logic [S_W-1:0]    sh_dn;
  logic [ACC_W+1:0]  up_w;
  logic [RND_W-1:0]  rnd_w;
  logic [RND_W-1:0]  dn_w;
  logic [OUT_W-1:0]  dens_nxt;
  logic              sat_nxt;

  logic              out_valid_r;
  logic [OUT_W-1:0]  density_r;
  logic              saturated_r;
  logic              tail_r;

  always_comb begin
    acc_f    = hacc_r[HORNER_TERMS-1];
    side_f   = hs3_r[HORNER_TERMS-1];
    sh_s     = $signed({1'b0, side_f.e}) - S_W'(SH_BIAS);
    sh_dn    = S_W'(-sh_s);
    up_w     = (ACC_W+2)'(acc_f) << sh_s[1:0];
    rnd_w    = RND_W'(acc_f) + (RND_W'(1) << (sh_dn - S_W'(1)));
    dn_w     = rnd_w >> sh_dn;
    dens_nxt = '0;
    sat_nxt  = 1'b0;
    if (!sh_s[S_W-1]) begin
      if ((sh_s > S_W'(MAX_UP)) || (|up_w[ACC_W+1:ACC_W])) begin
        dens_nxt = '1;
        sat_nxt  = 1'b1;
      end else begin
        dens_nxt = up_w[OUT_W-1:0];
      end
    end else if (sh_dn < S_W'(ZERO_SHIFT)) begin
      dens_nxt = dn_w[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hv3_r[HORNER_TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      density_r   <= dens_nxt;
      saturated_r <= sat_nxt;
      tail_r      <= side_f.tail;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_density   = density_r;
  assign out_saturated = saturated_r;
  assign out_tail      = tail_r;

endmodule

// File: hw/rtl/gauss_exp_tail_eval.sv
// gauss_exp_tail_eval: top level of the gaussian shape evaluator with exponential low tail
// depends on gete_pkg, gete_div, gete_expo, gete_fexp

// Evaluates exp(-0.5*r*r), r = (sample - mean)/width, for samples above switch_point,
// and below or at it the exponential that continues the gaussian with matching value
// and slope; all values are Q16.16, density is unsigned and saturates at all ones with
// the saturated flag set. The block takes one request per clock cycle while no stalled
// result holds the pipe, and every request gives exactly one result, in order. The pipe
// is one input register, FRAC_BITS + 33 restoring divider stages on Q16.16 data (one
// quotient bit per stage, which sets most of the depth), three exponent stages, three
// stages to split the exponent into powers of two, thirty series stages (ten terms of
// multiply, reciprocal multiply and correction) and the result register. The whole
// pipe advances together and holds when the result register is stalled, so in_stall
// rises only while a finished result waits. Registers are written through the cfg
// port (0 mean, 1 width, 2 switch_point; other indexes are ignored) and may only be
// written while no request is in flight; a width of zero acts as the smallest width.

module gauss_exp_tail_eval (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [gete_pkg::IN_W-1:0]  in_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gete_pkg::OUT_W-1:0]        out_density,
  output logic                              out_in_tail,
  output logic                              out_saturated,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gete_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gete_pkg::IN_W-1:0]         cfg_wdata
);
  import gete_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_SWITCH = 2'd2
  } reg_idx_t;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = WIDTH_W'(1) << FRAC_BITS;
  localparam logic [IN_W-1:0]    SWITCH_RST = {1'b1, {(IN_W-1){1'b0}}};

  // whole pipe moves unless the result register holds a stalled result
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic signed [IN_W-1:0] mean_r;
  logic [WIDTH_W-1:0]     width_r;
  logic signed [IN_W-1:0] switch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= '0;
      width_r  <= WIDTH_RST;
      switch_r <= SWITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEAN:   mean_r   <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_SWITCH: switch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero width behaves as one lsb
  logic [REM_W-1:0] divisor;
  assign divisor = (width_r == '0) ? REM_W'(1) : width_r;

  // input stage: branch select and dividend magnitudes
  logic                     tail_w;
  logic signed [DIFF_W-1:0] diff_a;
  logic signed [DIFF_W-1:0] diff_b;
  logic [DIFF_W-1:0]        mag_a;
  logic [DIFF_W-1:0]        mag_b;

  always_comb begin
    tail_w = in_sample <= switch_r;
    // tail: lane a carries (x - switch), lane b (switch - mean)
    diff_a = tail_w ? DIFF_W'(in_sample) - DIFF_W'(switch_r)
                    : DIFF_W'(in_sample) - DIFF_W'(mean_r);
    diff_b = DIFF_W'(switch_r) - DIFF_W'(mean_r);
    mag_a  = diff_a[DIFF_W-1] ? DIFF_W'(-diff_a) : DIFF_W'(diff_a);
    mag_b  = diff_b[DIFF_W-1] ? DIFF_W'(-diff_b) : DIFF_W'(diff_b);
  end

  logic             s0_valid_r;
  gete_tag_t        s0_tag_r;
  logic [DIV_W-1:0] s0_num_a_r;
  logic [DIV_W-1:0] s0_num_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tag_r   <= '{tail: tail_w, neg_a: diff_a[DIFF_W-1], neg_b: diff_b[DIFF_W-1]};
      s0_num_a_r <= {mag_a, {FRAC_BITS{1'b0}}};
      s0_num_b_r <= {mag_b, {FRAC_BITS{1'b0}}};
    end
  end

  // ratios
  logic             dv_valid;
  gete_tag_t        dv_tag;
  logic [DIV_W-1:0] dv_quo_a;
  logic [DIV_W-1:0] dv_quo_b;

  gete_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_tag    (s0_tag_r),
    .in_num_a  (s0_num_a_r),
    .in_num_b  (s0_num_b_r),
    .divisor   (divisor),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_quo_a (dv_quo_a),
    .out_quo_b (dv_quo_b)
  );

  // exponent magnitude and sign
  logic           ex_valid;
  logic [T_W-1:0] ex_t_mag;
  logic           ex_t_pos;
  logic           ex_tail;

  gete_expo u_expo (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_tag    (dv_tag),
    .in_quo_a  (dv_quo_a),
    .in_quo_b  (dv_quo_b),
    .out_valid (ex_valid),
    .out_t_mag (ex_t_mag),
    .out_t_pos (ex_t_pos),
    .out_tail  (ex_tail)
  );

  // exp and final scaling, ends in the result register
  gete_fexp u_fexp (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (ex_valid),
    .in_t_mag      (ex_t_mag),
    .in_t_pos      (ex_t_pos),
    .in_tail       (ex_tail),
    .out_valid     (out_valid),
    .out_density   (out_density),
    .out_saturated (out_saturated),
    .out_tail      (out_in_tail)
  );

endmodule

// File: hw/rtl/gete_checker.sv
// gete_checker: port-level checks of the evaluator, bound to the top level
// depends on gete_pkg and gauss_exp_tail_eval

module gete_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic signed [gete_pkg::IN_W-1:0]  in_sample,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [gete_pkg::OUT_W-1:0]        out_density,
  input logic                              out_in_tail,
  input logic                              out_saturated
);

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // saturation always comes with the all-ones density
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_density == '1))
    else $error("saturated result without maximum density");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_density)
      && $stable(out_saturated) && $stable(out_in_tail)))
    else $error("stalled result changed");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("result valid right after reset");

endmodule

bind gauss_exp_tail_eval gete_checker u_gete_checker (.*);

// File: verif/gauss_exp_tail_eval_test.sv
// gauss_exp_tail_eval_test: self-checking testbench of the gaussian/exponential-tail evaluator
// depends on gete_pkg and gauss_exp_tail_eval; predicts each result in fixed point and compares

module gauss_exp_tail_eval_test;
  import gete_pkg::*;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 120;
  localparam int ONE          = 1 << FRAC_BITS;

  typedef struct packed {
    logic [OUT_W-1:0] density;
    logic             in_tail;
    logic             saturated;
  } shape_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [IN_W-1:0] in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_density;
  logic                 out_in_tail;
  logic                 out_saturated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IN_W-1:0]      cfg_wdata;

  // our own copy of the registers
  logic [31:0] cur_mean;
  logic [30:0] cur_width;
  logic [31:0] cur_switch;

  shape_t shape_q[$];
  int     errors;
  int     idle_cycles;
  int     burst_left;
  int     stall_mode;

  gauss_exp_tail_eval dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_density(out_density),
    .out_in_tail(out_in_tail), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- prediction ----------------

  // (num << FRAC_BITS) / w truncated toward zero, sign of num
  function automatic longint scaled_ratio(longint num, longint unsigned w);
    longint unsigned m;
    m = ((num < 0 ? -num : num) << FRAC_BITS) / w;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  // (a*b) >> (F+1), exact, clamped to 64.0
  function automatic longint unsigned half_product(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    logic [127:0] lim;
    lim = 128'(64) << FRAC_BITS;
    p = (128'(a) * 128'(b)) >> (FRAC_BITS + 1);
    return p > lim ? longint'(lim) : longint'(p[63:0]);
  endfunction

  // exp(t) with 2^k split and a ten-term series for the fraction
  function automatic shape_t exp_fixed(longint t);
    longint unsigned um, ub, f, v, acc, r;
    longint          k, s;
    shape_t          res;
    um = ((t < 0 ? -t : t) * 64'd1549082005) >> FRAC_BITS;
    ub = t < 0 ? (64'd128 << 30) - um : (64'd128 << 30) + um;
    k = longint'(ub >> 30) - 128;
    f = ub & ((64'd1 << 30) - 1);
    v = (f * 64'd744261118) >> 30;
    acc = 64'd1 << 30;
    for (int n = 10; n >= 1; n--)
      acc = (64'd1 << 30) + ((acc * v) >> 30) / n;
    s = k + FRAC_BITS - 30;
    res = '0;
    if (s >= 0) begin
      r = acc << s;
      if (s > 2 || r > 64'hFFFF_FFFF) begin
        res.density = '1;
        res.saturated = 1'b1;
      end else begin
        res.density = r[31:0];
      end
    end else if (-s < 40) begin
      r = (acc + (64'd1 << (-s - 1))) >> (-s);
      res.density = r[31:0];
    end
    return res;
  endfunction

  function automatic shape_t predict_shape(logic [31:0] smp);
    longint          x, m0, m1, r, r1, d, q, t;
    longint unsigned w, p;
    shape_t          res;
    x  = longint'($signed(smp));
    m0 = longint'($signed(cur_mean));
    m1 = longint'($signed(cur_switch));
    w  = cur_width == 0 ? 1 : longint'(cur_width);
    if (x > m1) begin
      r = scaled_ratio(x - m0, w);
      if (r < 0) r = -r;
      t = -longint'(half_product(r, r));
    end else begin
      r1 = scaled_ratio(m1 - m0, w);
      d  = scaled_ratio(x - m1, w);
      q  = r1 + 2 * d;
      p  = half_product(r1 < 0 ? -r1 : r1, q < 0 ? -q : q);
      t  = ((r1 < 0) != (q < 0)) ? longint'(p) : -longint'(p);
    end
    res = exp_fixed(t);
    res.in_tail = x <= m1;
    return res;
  endfunction

  // ---------------- result check ----------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (shape_q.size() == 0) begin
        $error("unexpected result density=%h", out_density);
        errors++;
      end else begin
        shape_t e;
        e = shape_q.pop_front();
        if (out_density !== e.density) begin
          $error("density expected %h actual %h", e.density, out_density);
          errors++;
        end
        if (out_in_tail !== e.in_tail) begin
          $error("in_tail expected %b actual %b", e.in_tail, out_in_tail);
          errors++;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: free running, random or long bursts, mode changes now and then
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("gauss_exp_tail_eval_test failed");
      $finish;
    end
  end

  // ---------------- drivers ----------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MEAN:   cur_mean = val;
      REG_WIDTH:  cur_width = val[30:0];
      REG_SWITCH: cur_switch = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // every request accepted so far has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shape_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_shape(input logic [31:0] m, input logic [31:0] w, input logic [31:0] sw);
    wait_drained();
    write_reg(REG_MEAN, m);
    write_reg(REG_WIDTH, w);
    write_reg(REG_SWITCH, sw);
  endtask

  // one request; valid stays high across a burst, gaps in between
  task automatic send_sample(input logic [31:0] smp);
    in_valid <= 1'b1;
    in_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shape_q.push_back(predict_shape(smp));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // ---------------- tests ----------------

  // reset values: switch at the most negative value, so only that sample hits the tail
  task automatic test_reset_values();
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0001);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(ONE);
    send_sample(-ONE);
    send_sample(3 * ONE);
  endtask

  // tail on both sides of the mean, including a growing tail that saturates
  task automatic test_tail_branch();
    set_shape(0, ONE, -2 * ONE);
    send_sample(-2 * ONE);
    send_sample(-2 * ONE + 1);
    send_sample(-5 * ONE);
    send_sample(32'h8000_0000);
    set_shape(0, ONE, 2 * ONE);
    send_sample(2 * ONE);
    send_sample(-40 * ONE);
    send_sample(32'h8000_0000);
    send_sample(ONE);
  endtask

  // width extremes, the zero width, register extremes and the unused index
  task automatic test_extremes();
    set_shape(0, 0, 32'h8000_0000);
    send_sample(1);
    send_sample(0);
    set_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    set_shape(32'h8000_0000, 1, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    wait_drained();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_sample(0);
  endtask

  // random shapes, samples mostly within a few widths of the mean or switch
  task automatic test_random_phases();
    logic [31:0] m, w, sw, smp;
    for (int ph = 0; ph < 10; ph++) begin
      m = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40 * ONE) - 20 * ONE;
      case ($urandom_range(0, 4))
        0: w = $urandom_range(1, 255);
        1: w = $urandom() & 32'h7FFF_FFFF;
        default: w = $urandom_range(ONE / 16, 8 * ONE);
      endcase
      case ($urandom_range(0, 3))
        0: sw = $urandom();
        1: sw = 32'h8000_0000;
        default: sw = m + $urandom_range(0, 8 * w[30:0]) - 4 * w[30:0];
      endcase
      set_shape(m, w, sw);
      for (int i = 0; i < 170; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: smp = $urandom();
          3, 4: smp = sw + $urandom_range(0, 16 * w[30:0]) - 12 * w[30:0];
          default: smp = m + $urandom_range(0, 12 * w[30:0]) - 6 * w[30:0];
        endcase
        send_sample(smp);
        // sender holds off until the pipe is empty, once per phase
        if (i == 85) wait_drained();
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MEAN;
    cfg_wdata = '0;
    cur_mean = 0;
    cur_width = ONE;
    cur_switch = 32'h8000_0000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_tail_branch();
    test_extremes();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("gauss_exp_tail_eval_test passed");
    else
      $display("gauss_exp_tail_eval_test failed");
    $finish;
  end

endmodule
